/* sv/pbid_pkg.sv */
// shared types, constants and helpers for the box iou distance core
package pbid_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned BOX_W     = 4 * COORD_W;
  localparam int unsigned EXT_W     = COORD_W + 1;
  localparam int unsigned AREA_W    = 2 * EXT_W;
  localparam int unsigned Q_W       = 17;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned IDX_OUT_W = 5;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [Q_W-1:0] Q_ONE      = 17'h10000;
  localparam logic [Q_W-1:0] THR_RESET  = 17'h08000;

  // left sits in the low lane
  typedef struct packed {
    logic signed [COORD_W-1:0] bottom;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] left;
  } box_t;

  typedef struct packed {
    logic take;
    logic store_first;
    logic area;
    logic rd;
    logic ext;
    logic mul_inter;
    logic mul_b;
    logic uni;
    logic div_start;
    logic emit_pair;
    logic emit_ovf;
    logic store_cur;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic pair_last;
    logic div_busy;
    logic out_free;
  } ctrl_sts_t;

  // inclusive pixel extent, negative counts as zero
  function automatic logic [EXT_W-1:0] extent_f(input logic signed [COORD_W-1:0] lo,
                                               input logic signed [COORD_W-1:0] hi);
    logic signed [EXT_W:0] d;
    d = $signed({{2{hi[COORD_W-1]}}, hi}) - $signed({{2{lo[COORD_W-1]}}, lo}) + 18'sd1;
    if (d > 18'sd0) begin
      return d[EXT_W-1:0];
    end
    return '0;
  endfunction

endpackage

/* sv/pbid_div.sv */
// serial restoring divider, one quotient bit per cycle
module pbid_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pbid_pkg::AREA_W-1:0]  num_i,
  input  logic [pbid_pkg::AREA_W-1:0]  den_i,
  output logic                         busy_o,
  output logic [pbid_pkg::Q_W-1:0]     quot_o
);
  import pbid_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [AREA_W-1:0]    rem_q, rem_d;
  logic [Q_W-1:0]       quot_q;
  logic                 lsb_q;
  logic                 in_bit;
  logic [AREA_W:0]      shifted;
  logic                 qbit;

  // dividend is num << 16; its bits above 16 seed the remainder
  assign in_bit  = (cnt_q == '0) ? lsb_q : 1'b0;
  assign shifted = {rem_q, in_bit};
  assign qbit    = (shifted >= {1'b0, den_i});

  always_comb begin
    if (qbit) begin
      rem_d = AREA_W'(shifted - {1'b0, den_i});
    end else begin
      rem_d = shifted[AREA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(Q_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i >> 1;
      lsb_q <= num_i[0];
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[Q_W-2:0], qbit};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

/* sv/pbid_dp.sv */
// datapath: box store, extents, shared multiplier, divider and output register
module pbid_dp #(
  parameter int unsigned MAX_BOXES = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pbid_pkg::ctrl_cmd_t               cmd_i,
  output pbid_pkg::ctrl_sts_t               sts_o,
  input  logic [pbid_pkg::BOX_W-1:0]        box_i,
  input  logic                              cfg_we_i,
  input  logic [pbid_pkg::Q_W-1:0]          cfg_wdata_i,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [pbid_pkg::OUT_TDATA_W-1:0]  m_data_o,
  output logic [pbid_pkg::OUT_TUSER_W-1:0]  m_user_o,
  output logic                              m_last_o
);
  import pbid_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned XJ = (IW > IDX_OUT_W) ? IW : IDX_OUT_W;
  localparam int unsigned XC = (CW > IDX_OUT_W) ? CW : IDX_OUT_W;

  logic [BOX_W-1:0] mem_q [MAX_BOXES];
  logic [BOX_W-1:0] rdata_q;
  logic             we;
  logic [IW-1:0]    waddr;
  logic [BOX_W-1:0] wdata;

  box_t             cur_q, in_box, old_box;
  logic [CW-1:0]    count_q;
  logic [IW-1:0]    j_q;
  logic [Q_W-1:0]   thr_q;

  logic [EXT_W-1:0] cur_w_q, cur_h_q, cw_q, ch_q, bw_q, bh_q;
  logic             sep_q, force_one_q;
  logic [AREA_W-1:0] a1_q, a2_q, inter_q, uni_q;
  logic [AREA_W:0]   uni_d;

  logic [EXT_W-1:0]  op_a, op_b;
  logic [AREA_W-1:0] prod;

  logic              div_busy;
  logic [Q_W-1:0]    quot;
  logic [Q_W-1:0]    pair_dist;
  logic [XJ-1:0]     j_ext;
  logic [XC-1:0]     c_ext;
  logic              pair_last;

  logic                 out_valid_q;
  logic [IDX_OUT_W-1:0] out_early_q, out_new_q;
  logic [Q_W-1:0]       out_dist_q;
  logic                 out_far_q, out_ovf_q, out_last_q;

  assign in_box  = box_t'(box_i);
  assign old_box = box_t'(rdata_q);

  // store: first box of a set at entry 0, later boxes at the fill count
  assign we    = cmd_i.store_first | cmd_i.store_cur;
  assign waddr = cmd_i.store_first ? '0 : count_q[IW-1:0];
  assign wdata = cmd_i.store_first ? box_i : BOX_W'(cur_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[j_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      j_q     <= '0;
      thr_q   <= THR_RESET;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.store_first) begin
        count_q <= CW'(1);
      end else if (cmd_i.store_cur) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.take || cmd_i.store_cur) begin
        j_q <= '0;
      end else if (cmd_i.emit_pair) begin
        j_q <= j_q + IW'(1);
      end
    end
  end

  // one multiplier, operands picked by the step
  always_comb begin
    priority if (cmd_i.area) begin
      op_a = cur_w_q;
      op_b = cur_h_q;
    end else if (cmd_i.mul_inter) begin
      op_a = cw_q;
      op_b = ch_q;
    end else begin
      op_a = bw_q;
      op_b = bh_q;
    end
  end
  assign prod  = AREA_W'(op_a) * AREA_W'(op_b);
  assign uni_d = {1'b0, a1_q} + {1'b0, a2_q} - {1'b0, inter_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cur_q   <= in_box;
      cur_w_q <= extent_f(in_box.left, in_box.right);
      cur_h_q <= extent_f(in_box.top, in_box.bottom);
    end
    if (cmd_i.area) begin
      a1_q <= prod;
    end
    if (cmd_i.ext) begin
      sep_q <= (cur_q.left > old_box.right) || (cur_q.top > old_box.bottom) ||
               (cur_q.right < old_box.left) || (cur_q.bottom < old_box.top);
      cw_q  <= extent_f((cur_q.left > old_box.left) ? cur_q.left : old_box.left,
                        (cur_q.right < old_box.right) ? cur_q.right : old_box.right);
      ch_q  <= extent_f((cur_q.top > old_box.top) ? cur_q.top : old_box.top,
                        (cur_q.bottom < old_box.bottom) ? cur_q.bottom : old_box.bottom);
      bw_q  <= extent_f(old_box.left, old_box.right);
      bh_q  <= extent_f(old_box.top, old_box.bottom);
    end
    if (cmd_i.mul_inter) begin
      inter_q <= prod;
    end
    if (cmd_i.mul_b) begin
      a2_q <= prod;
    end
    if (cmd_i.uni) begin
      uni_q       <= uni_d[AREA_W-1:0];
      force_one_q <= sep_q || (uni_d == '0);
    end
  end

  pbid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (inter_q),
    .den_i   (uni_q),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // iou never exceeds one, clamp kept for safety
  assign pair_dist = force_one_q ? Q_ONE : ((quot > Q_ONE) ? '0 : Q_ONE - quot);

  assign j_ext     = XJ'(j_q);
  assign c_ext     = XC'(count_q);
  assign pair_last = (CW'(j_q) + CW'(1)) == count_q;

  assign sts_o.empty     = (count_q == '0);
  assign sts_o.full      = (count_q == CW'(MAX_BOXES));
  assign sts_o.pair_last = pair_last;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.out_free  = !out_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_pair || cmd_i.emit_ovf) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pair) begin
      out_early_q <= j_ext[IDX_OUT_W-1:0];
      out_new_q   <= c_ext[IDX_OUT_W-1:0];
      out_dist_q  <= pair_dist;
      out_far_q   <= pair_dist > thr_q;
      out_ovf_q   <= 1'b0;
      out_last_q  <= pair_last;
    end else if (cmd_i.emit_ovf) begin
      out_early_q <= '0;
      out_new_q   <= '0;
      out_dist_q  <= '0;
      out_far_q   <= 1'b0;
      out_ovf_q   <= 1'b1;
      out_last_q  <= 1'b1;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {(OUT_TDATA_W - Q_W - 2 * IDX_OUT_W)'(0), out_dist_q, out_new_q, out_early_q};
  assign m_user_o  = {out_ovf_q, out_far_q};
  assign m_last_o  = out_last_q;

endmodule

/* sv/pbid_ctrl.sv */
// controller: sequences accept, per-pair steps and result hand-off
module pbid_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  start_i,
  output logic                  s_ready_o,
  input  pbid_pkg::ctrl_sts_t   sts_i,
  output pbid_pkg::ctrl_cmd_t   cmd_o
);
  import pbid_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AREA,
    ST_READ,
    ST_EXT,
    ST_MUL1,
    ST_MUL2,
    ST_UNI,
    ST_DSTART,
    ST_DIV,
    ST_EMIT,
    ST_OVF
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign s_ready_o = (state_q == ST_IDLE);
  assign acc       = s_valid_i && s_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          cmd_o.take = 1'b1;
          priority if (start_i || sts_i.empty) begin
            cmd_o.store_first = 1'b1;
          end else if (sts_i.full) begin
            state_d = ST_OVF;
          end else begin
            state_d = ST_AREA;
          end
        end
      end
      ST_AREA: begin
        cmd_o.area = 1'b1;
        state_d    = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EXT;
      end
      ST_EXT: begin
        cmd_o.ext = 1'b1;
        state_d   = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul_inter = 1'b1;
        state_d         = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_UNI;
      end
      ST_UNI: begin
        cmd_o.uni = 1'b1;
        state_d   = ST_DSTART;
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_pair = 1'b1;
          if (sts_i.pair_last) begin
            cmd_o.store_cur = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_OVF: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ovf = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/pairwise_box_iou_distance_core.sv */
// top level of the pairwise box iou distance core
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: left,top,right,bottom; tuser: start_set
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: earlier,new index,distance; tuser; tlast
//  cfg       in   cfg_we_i                      cfg_wdata_i: distance threshold
//
//  a box that starts a set or lands in an empty store is stored and gives no result
//  a box against n stored boxes gives n results, each pair waits on the serial divider
//  an overflow box gives one overflow result; a stalled output holds the pair loop in place
//  reset empties the store and sets the threshold to one half; no clearing pass
module pairwise_box_iou_distance_core #(
  parameter int unsigned MAX_BOXES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // left, top, right, bottom
  input  logic        s_axis_tuser,   // start_set
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // earlier_index, new_index, distance, zero pad
  output logic [1:0]  m_axis_tuser,   // far_apart, overflow
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i
);
  import pbid_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  pbid_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .start_i   (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pbid_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .box_i       (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser),
    .m_last_o    (m_axis_tlast)
  );

  // an overflow result closes its request
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("overflow result without last");

  // overflow result carries no distance and no far flag
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata[26:10] == 17'd0) && !m_axis_tuser[0])
    else $error("overflow result with payload");

  // results are only loaded when the output register can take them
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_pair || cmd.emit_ovf |-> sts.out_free)
    else $error("result loaded over a waiting one");

  // at most one of first-box store, pair result load and overflow load per cycle
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.store_first, cmd.emit_pair, cmd.emit_ovf}))
    else $error("conflicting datapath commands");

endmodule

/* verif/testbench.sv */
// self-checking testbench for the pairwise box iou distance core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pbid_pkg::*;

  localparam int unsigned BOX_CAP       = 32;
  localparam int unsigned RANDOM_ITEMS  = 130;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] earlier_idx;
    logic [IDX_OUT_W-1:0] new_idx;
    logic [Q_W-1:0]       distance;
    logic                 far_apart;
    logic                 overflow;
    logic                 last;
  } pair_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // left, top, right, bottom
  logic        s_axis_tuser = 1'b0; // start_set
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // earlier_index, new_index, distance, zero pad
  logic [1:0]  m_axis_tuser;        // far_apart, overflow
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;

  // predictor state
  box_t           stored_boxes [BOX_CAP];
  int unsigned    stored_count = 0;
  logic [Q_W-1:0] dist_threshold = THR_RESET;
  pair_result_t   pair_results_q [$];

  int unsigned fail_count = 0;
  bit          gaps_on = 1'b1;
  int unsigned rx_hold_request = 0;

  pairwise_box_iou_distance_core #(
    .MAX_BOXES(BOX_CAP)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic longint unsigned pixel_span(input longint lo, input longint hi);
    longint e;
    e = hi - lo + 1;
    return (e > 0) ? longint'(e) : 64'd0;
  endfunction

  // one minus iou in q1.16, iou rounded down
  function automatic logic [Q_W-1:0] iou_distance_q16(input box_t a, input box_t b);
    longint al, at, ar, ab, bl, bt, br, bb;
    longint unsigned inter, area_a, area_b, uni, ratio;
    al = a.left;  at = a.top;  ar = a.right;  ab = a.bottom;
    bl = b.left;  bt = b.top;  br = b.right;  bb = b.bottom;
    if (al > br || at > bb || ar < bl || ab < bt) return Q_ONE;
    inter = pixel_span((al > bl) ? al : bl, (ar < br) ? ar : br) *
            pixel_span((at > bt) ? at : bt, (ab < bb) ? ab : bb);
    area_a = pixel_span(al, ar) * pixel_span(at, ab);
    area_b = pixel_span(bl, br) * pixel_span(bt, bb);
    uni = area_a + area_b - inter;
    if (uni == 0) return Q_ONE;
    ratio = (inter << 16) / uni;
    if (ratio > 64'd65536) ratio = 64'd65536;
    return Q_W'(64'd65536 - ratio);
  endfunction

  function automatic void predict_box(input logic start, input box_t box);
    pair_result_t r;
    if (start || stored_count == 0) begin
      stored_boxes[0] = box;
      stored_count = 1;
      return;
    end
    if (stored_count >= BOX_CAP) begin
      r = '0;
      r.overflow = 1'b1;
      r.last = 1'b1;
      pair_results_q.push_back(r);
      return;
    end
    for (int unsigned j = 0; j < stored_count; j++) begin
      r.earlier_idx = IDX_OUT_W'(j);
      r.new_idx     = IDX_OUT_W'(stored_count);
      r.distance    = iou_distance_q16(box, stored_boxes[j]);
      r.far_apart   = r.distance > dist_threshold;
      r.overflow    = 1'b0;
      r.last        = (j + 1 == stored_count);
      pair_results_q.push_back(r);
    end
    stored_boxes[stored_count] = box;
    stored_count++;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic int unsigned pick_gap(input int unsigned short_pct,
                                           input int unsigned long_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < long_pct) return $urandom_range(40, 10);
    if (roll < long_pct + short_pct) return $urandom_range(3, 1);
    return 0;
  endfunction

  function automatic box_t make_box(input int l, input int t, input int r, input int b);
    box_t bx;
    bx.left = 16'(l);
    bx.top = 16'(t);
    bx.right = 16'(r);
    bx.bottom = 16'(b);
    return bx;
  endfunction

  function automatic logic [15:0] edge_coord();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // mostly small boxes around a set center so that pairs overlap
  function automatic box_t random_box(input int cx, input int cy);
    box_t b;
    int unsigned pick;
    int l, t, w, h;
    pick = $urandom_range(99);
    if (pick < 8) begin
      b = {$urandom, $urandom};
      return b;
    end
    if (pick < 12) begin
      b.left = edge_coord();
      b.top = edge_coord();
      b.right = edge_coord();
      b.bottom = edge_coord();
      return b;
    end
    l = cx + int'($urandom_range(60)) - 30;
    t = cy + int'($urandom_range(60)) - 30;
    w = int'($urandom_range(40));
    h = int'($urandom_range(40));
    if (pick < 17) w = -int'($urandom_range(6));
    else if (pick < 22) h = -int'($urandom_range(6));
    return make_box(l, t, l + w, t + h);
  endfunction

  // receiver: random stalls plus the long hold-off on demand
  initial begin : rx_ready_gen
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_request != 0) begin
        stall_left = rx_hold_request;
        rx_hold_request = 0;
      end
      if (stall_left == 0 && gaps_on) stall_left = pick_gap(15, 2);
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_pair_result();
  end

  task automatic check_pair_result();
    pair_result_t want;
    if (pair_results_q.size() == 0) begin
      $error("unexpected result: tdata=%h tuser=%b tlast=%b",
             m_axis_tdata, m_axis_tuser, m_axis_tlast);
      fail_count++;
      return;
    end
    want = pair_results_q.pop_front();
    compare_field("earlier_index", 32'(want.earlier_idx), 32'(m_axis_tdata[IDX_OUT_W-1:0]));
    compare_field("new_index", 32'(want.new_idx),
                  32'(m_axis_tdata[2*IDX_OUT_W-1:IDX_OUT_W]));
    compare_field("distance", 32'(want.distance),
                  32'(m_axis_tdata[2*IDX_OUT_W+Q_W-1:2*IDX_OUT_W]));
    compare_field("far_apart", 32'(want.far_apart), 32'(m_axis_tuser[0]));
    compare_field("overflow", 32'(want.overflow), 32'(m_axis_tuser[1]));
    compare_field("last", 32'(want.last), 32'(m_axis_tlast));
  endtask

  // hold the request until the core takes it; valid stays up for a back-to-back box
  task automatic send_box(input logic start, input box_t box);
    int unsigned gap;
    gap = gaps_on ? pick_gap(30, 5) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= box;
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_box(start, box);
  endtask

  // wait for every pending result, then let the pair loop wind down
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    while (pair_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [Q_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dist_threshold = value;
  endtask

  task automatic test_directed_geometry();
    // first box lands in an empty store without a start flag
    send_box(1'b0, make_box(0, 0, 9, 9));
    send_box(1'b0, make_box(5, 5, 14, 14));
    send_box(1'b0, make_box(0, 0, 9, 9));
    // edge-adjacent on x, then on y: no overlap
    send_box(1'b0, make_box(10, 0, 19, 9));
    send_box(1'b0, make_box(0, 10, 9, 19));
    send_box(1'b0, make_box(-32768, -32768, 32767, 32767));
    send_box(1'b0, make_box(32767, 32767, 32767, 32767));
    send_box(1'b0, make_box(-32768, -32768, -32768, -32768));
    // negative width and negative height
    send_box(1'b0, make_box(20, 0, 10, 9));
    send_box(1'b0, make_box(0, 20, 9, 10));
    // thirds that force the round-down
    send_box(1'b1, make_box(0, 0, 1, 0));
    send_box(1'b0, make_box(1, 0, 2, 0));
    send_box(1'b0, make_box(0, 0, 2, 0));
    finish_phase();
  endtask

  task automatic sweep_threshold(input logic [Q_W-1:0] value);
    write_threshold(value);
    send_box(1'b1, make_box(0, 0, 9, 9));
    send_box(1'b0, make_box(0, 0, 9, 9));
    send_box(1'b0, make_box(50, 50, 59, 59));
    finish_phase();
  endtask

  task automatic test_threshold_extremes();
    sweep_threshold(17'd0);
    sweep_threshold(17'd1);
    sweep_threshold(Q_ONE - 17'd1);
    sweep_threshold(Q_ONE);
  endtask

  // fill the store, then two dropped boxes, then a fresh set
  task automatic test_full_set();
    int cx, cy;
    write_threshold(THR_RESET);
    cx = int'($urandom_range(64000)) - 32000;
    cy = int'($urandom_range(64000)) - 32000;
    for (int unsigned k = 0; k < BOX_CAP + 2; k++) send_box(k == 0, random_box(cx, cy));
    send_box(1'b1, random_box(cx, cy));
    send_box(1'b0, random_box(cx, cy));
    finish_phase();
  endtask

  // long receiver hold-off while boxes keep coming
  task automatic test_backpressure();
    gaps_on = 1'b0;
    rx_hold_request = HOLD_CYCLES;
    send_box(1'b1, make_box(100, 100, 130, 120));
    for (int k = 1; k < 10; k++) send_box(1'b0, make_box(100 + k, 98 + 2 * k, 125 + k, 121));
    finish_phase();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_sets();
    int unsigned sent, set_len;
    int cx, cy;
    logic start;
    logic [Q_W-1:0] thr;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(5))
        0: thr = '0;
        1: thr = Q_ONE;
        default: thr = Q_W'($urandom_range(65536));
      endcase
      write_threshold(thr);
      gaps_on = ($urandom_range(3) != 0);
      repeat ($urandom_range(4, 2)) begin
        set_len = ($urandom_range(9) == 0) ? $urandom_range(14, 7) : $urandom_range(5, 1);
        cx = int'($urandom_range(64000)) - 32000;
        cy = int'($urandom_range(64000)) - 32000;
        for (int unsigned k = 0; k < set_len; k++) begin
          // now and then a set carries on the previous one or restarts midway
          if (k == 0) start = ($urandom_range(7) != 0);
          else start = ($urandom_range(15) == 0);
          send_box(start, random_box(cx, cy));
          sent++;
        end
      end
      finish_phase();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_geometry();
    test_threshold_extremes();
    test_full_set();
    test_backpressure();
    test_random_sets();
    finish_phase();
    if (fail_count == 0 && pair_results_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
